>>> src/bts_pkg.sv
package bts_pkg;

  localparam int PHASE_COUNT = 3;
  localparam int MIN_W       = 13;
  localparam int TS_W        = 32;
  localparam int STEP_W      = 6;
  localparam int MS_W        = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  // Phase codes
  localparam logic [1:0] PHASE_KNEAD = 2'd0;
  localparam logic [1:0] PHASE_BAKE  = 2'd1;
  localparam logic [1:0] PHASE_RAISE = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_LONG_PRESS = 3'd0;
  localparam logic [2:0] REG_REPEAT     = 3'd1;
  localparam logic [2:0] REG_FAST_HOLD  = 3'd2;
  localparam logic [2:0] REG_FAST_STEP  = 3'd3;
  localparam logic [2:0] REG_MAX_MIN    = 3'd4;

  localparam logic [MS_W-1:0]   LONG_PRESS_RST = 16'd500;
  localparam logic [MS_W-1:0]   REPEAT_RST     = 16'd200;
  localparam logic [MS_W-1:0]   FAST_HOLD_RST  = 16'd2000;
  localparam logic [STEP_W-1:0] FAST_STEP_RST  = 6'd5;
  localparam logic [MIN_W-1:0]  MAX_MIN_RST    = 13'(99 * 60 + 59);

  localparam logic [MIN_W-1:0] PHASE_MIN_RST [PHASE_COUNT] = '{13'd25, 13'd90, 13'd40};

  typedef struct packed {
    logic [MS_W-1:0]   long_press_ms;
    logic [MS_W-1:0]   repeat_interval_ms;
    logic [MS_W-1:0]   fast_hold_ms;
    logic [STEP_W-1:0] fast_step;
    logic [MIN_W-1:0]  max_minutes;
  } bts_cfg_t;

  // One scan, with the up/down levels already classified
  typedef struct packed {
    logic [TS_W-1:0] now_ms;
    logic            mode_level;
    logic            up_level;
    logic            down_level;
    logic            held;
    logic            dir_up;
  } bts_item_t;

  function automatic logic [1:0] next_phase(input logic [1:0] p);
    logic [1:0] n;
    n = PHASE_KNEAD;
    if (p == PHASE_KNEAD) n = PHASE_RAISE;
    else if (p == PHASE_RAISE) n = PHASE_BAKE;
    return n;
  endfunction

endpackage

>>> src/bts_front.sv
module bts_front
  import bts_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [TS_W-1:0] in_now_ms,
  input  logic            in_mode_level,
  input  logic            in_up_level,
  input  logic            in_down_level,
  output logic            item_valid,
  output bts_item_t       item,
  input  logic            item_ready
);

  logic      valid_r, valid_nxt;
  bts_item_t item_r, item_nxt;
  logic      accept;

  assign in_ready = !valid_r || item_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt           = 1'b1;
      item_nxt.now_ms     = in_now_ms;
      item_nxt.mode_level = in_mode_level;
      item_nxt.up_level   = in_up_level;
      item_nxt.down_level = in_down_level;
      // down wins over up when both are held
      item_nxt.held       = !in_down_level || !in_up_level;
      item_nxt.dir_up     = in_down_level;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> src/bts_queue.sv
module bts_queue
  import bts_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  bts_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output bts_item_t pop_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bts_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> src/bts_back.sv
module bts_back
  import bts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  bts_cfg_t         cfg,
  input  logic             item_valid,
  output logic             item_ready,
  input  bts_item_t        item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_setting_mode,
  output logic [1:0]       out_selected_phase,
  output logic [MIN_W-1:0] out_selected_minutes,
  output logic             out_value_changed
);

  logic             mode_r, mode_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [MIN_W-1:0] min_r [PHASE_COUNT];
  logic [MIN_W-1:0] min_nxt [PHASE_COUNT];
  logic [5:0]       hist_r, hist_nxt;
  logic             just_r, just_nxt;
  logic [TS_W-1:0]  mode_at_r, mode_at_nxt;
  logic             rep_act_r, rep_act_nxt;
  logic             rep_up_r, rep_up_nxt;
  logic [TS_W-1:0]  step_at_r, step_at_nxt;
  logic [TS_W-1:0]  next_rep_r, next_rep_nxt;

  logic             ovalid_r, ovalid_nxt;
  logic             omode_r, omode_nxt;
  logic [1:0]       ophase_r, ophase_nxt;
  logic [MIN_W-1:0] omin_r, omin_nxt;
  logic             ochg_r, ochg_nxt;

  logic fire;

  assign item_ready = !ovalid_r || out_ready;
  assign fire       = item_valid && item_ready;

  always_comb begin
    logic             mprev;
    logic             up_prev;
    logic             dn_prev;
    logic             btn_edge;
    logic             do_step;
    logic             phase_ok;
    logic [STEP_W-1:0] amount;
    logic [TS_W-1:0]  d_mode;
    logic [TS_W-1:0]  d_rep;
    logic [TS_W-1:0]  d_hold;
    logic [MIN_W-1:0] cur_min;
    logic [MIN_W-1:0] stepped;
    logic [MIN_W:0]   sum;

    mode_nxt     = mode_r;
    phase_nxt    = phase_r;
    min_nxt      = min_r;
    hist_nxt     = hist_r;
    just_nxt     = just_r;
    mode_at_nxt  = mode_at_r;
    rep_act_nxt  = rep_act_r;
    rep_up_nxt   = rep_up_r;
    step_at_nxt  = step_at_r;
    next_rep_nxt = next_rep_r;
    ovalid_nxt   = ovalid_r;
    omode_nxt    = omode_r;
    ophase_nxt   = ophase_r;
    omin_nxt     = omin_r;
    ochg_nxt     = ochg_r;

    mprev    = hist_r[0];
    up_prev  = hist_r[2];
    dn_prev  = hist_r[4];
    btn_edge = 1'b0;
    do_step  = 1'b0;
    phase_ok = 1'b0;
    amount   = STEP_W'(1);
    d_mode   = item.now_ms - mode_at_r;
    d_rep    = item.now_ms - next_rep_r;
    d_hold   = item.now_ms - step_at_r;
    cur_min  = '0;
    stepped  = '0;
    sum      = '0;

    if (fire) begin
      hist_nxt[1:0] = {mprev, item.mode_level};
      if (mprev != item.mode_level && !item.mode_level) begin
        if (!mode_r) begin
          mode_nxt  = 1'b1;
          phase_nxt = PHASE_KNEAD;
          just_nxt  = 1'b1;
        end else begin
          mode_at_nxt = item.now_ms;
        end
      end else if (mprev != item.mode_level) begin
        if (mode_r && !just_r) begin
          if (d_mode >= {16'd0, cfg.long_press_ms}) begin
            mode_nxt = 1'b0;
          end else begin
            phase_nxt = next_phase(phase_r);
          end
        end
        just_nxt = 1'b0;
      end

      if (mode_nxt) begin
        hist_nxt[5:2] = {dn_prev, item.down_level, up_prev, item.up_level};
        btn_edge = (up_prev != item.up_level) || (dn_prev != item.down_level);
        if (item.held) begin
          rep_up_nxt = item.dir_up;
        end
        if (btn_edge && item.held) begin
          step_at_nxt  = item.now_ms;
          rep_act_nxt  = 1'b1;
          next_rep_nxt = item.now_ms + {15'd0, cfg.repeat_interval_ms, 1'b0};
          do_step      = 1'b1;
        end else if (btn_edge) begin
          rep_act_nxt = 1'b0;
        end else if (rep_act_r) begin
          if (!d_rep[TS_W-1] && d_rep >= {16'd0, cfg.repeat_interval_ms}) begin
            next_rep_nxt = item.now_ms;
            do_step      = 1'b1;
            if (d_hold >= {16'd0, cfg.fast_hold_ms}) begin
              amount = cfg.fast_step;
            end
          end
        end
      end

      phase_ok = phase_nxt < 2'(PHASE_COUNT);
      if (phase_ok) begin
        cur_min = min_r[phase_nxt];
      end

      // Saturate to 0..max
      if (rep_up_nxt) begin
        sum     = {1'b0, cur_min} + (MIN_W + 1)'(amount);
        stepped = (sum > {1'b0, cfg.max_minutes}) ? cfg.max_minutes : sum[MIN_W-1:0];
      end else begin
        stepped = (MIN_W'(amount) > cur_min) ? '0 : cur_min - MIN_W'(amount);
        if (stepped > cfg.max_minutes) begin
          stepped = cfg.max_minutes;
        end
      end

      ochg_nxt = 1'b0;
      omin_nxt = cur_min;
      if (do_step && phase_ok) begin
        min_nxt[phase_nxt] = stepped;
        ochg_nxt           = 1'b1;
        omin_nxt           = stepped;
      end
      ovalid_nxt = 1'b1;
      omode_nxt  = mode_nxt;
      ophase_nxt = phase_nxt;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      phase_r    <= PHASE_KNEAD;
      min_r      <= PHASE_MIN_RST;
      hist_r     <= '1;
      just_r     <= 1'b0;
      mode_at_r  <= '0;
      rep_act_r  <= 1'b0;
      rep_up_r   <= 1'b0;
      step_at_r  <= '0;
      next_rep_r <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      phase_r    <= phase_nxt;
      min_r      <= min_nxt;
      hist_r     <= hist_nxt;
      just_r     <= just_nxt;
      mode_at_r  <= mode_at_nxt;
      rep_act_r  <= rep_act_nxt;
      rep_up_r   <= rep_up_nxt;
      step_at_r  <= step_at_nxt;
      next_rep_r <= next_rep_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    omode_r  <= omode_nxt;
    ophase_r <= ophase_nxt;
    omin_r   <= omin_nxt;
    ochg_r   <= ochg_nxt;
  end

  assign out_valid            = ovalid_r;
  assign out_setting_mode     = omode_r;
  assign out_selected_phase   = ophase_r;
  assign out_selected_minutes = omin_r;
  assign out_value_changed    = ochg_r;

endmodule

>>> src/button_time_setter.sv
// Path: a scan is held in the front register, then the queue, then the output register
// of the back stage. Throughput: one scan per cycle sustained while out_ready holds;
// the back stage's update, which reads and writes all timing and phase state, sets it.
// Reset: synchronous, active low; restores idle mode, phase kneading, minutes 25/90/40,
// buttons released, registers to their defaults, and empties the front and the queue.
module button_time_setter
  import bts_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // scan channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TS_W-1:0]    in_now_ms,
  input  logic               in_mode_level,
  input  logic               in_up_level,
  input  logic               in_down_level,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_setting_mode,
  output logic [1:0]         out_selected_phase,
  output logic [MIN_W-1:0]   out_selected_minutes,
  output logic               out_value_changed,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  bts_cfg_t   cfg_r, cfg_nxt;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  logic      fr_valid, fr_ready;
  bts_item_t fr_item;
  logic      q_valid, q_ready;
  bts_item_t q_item;

  // ---------------------------------------------------------------------------
  // Register file: written in the access phase, always ready
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_LONG_PRESS: cfg_nxt.long_press_ms      = pwdata[MS_W-1:0];
        REG_REPEAT:     cfg_nxt.repeat_interval_ms = pwdata[MS_W-1:0];
        REG_FAST_HOLD:  cfg_nxt.fast_hold_ms       = pwdata[MS_W-1:0];
        REG_FAST_STEP:  cfg_nxt.fast_step          = pwdata[STEP_W-1:0];
        REG_MAX_MIN:    cfg_nxt.max_minutes        = pwdata[MIN_W-1:0];
        default: ; // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LONG_PRESS: prdata = PDATA_W'(cfg_r.long_press_ms);
      REG_REPEAT:     prdata = PDATA_W'(cfg_r.repeat_interval_ms);
      REG_FAST_HOLD:  prdata = PDATA_W'(cfg_r.fast_hold_ms);
      REG_FAST_STEP:  prdata = PDATA_W'(cfg_r.fast_step);
      REG_MAX_MIN:    prdata = PDATA_W'(cfg_r.max_minutes);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms      <= LONG_PRESS_RST;
      cfg_r.repeat_interval_ms <= REPEAT_RST;
      cfg_r.fast_hold_ms       <= FAST_HOLD_RST;
      cfg_r.fast_step          <= FAST_STEP_RST;
      cfg_r.max_minutes        <= MAX_MIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Front: capture each scan transaction and classify the up/down levels
  // ---------------------------------------------------------------------------
  bts_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_now_ms     (in_now_ms),
    .in_mode_level (in_mode_level),
    .in_up_level   (in_up_level),
    .in_down_level (in_down_level),
    .item_valid    (fr_valid),
    .item          (fr_item),
    .item_ready    (fr_ready)
  );

  // ---------------------------------------------------------------------------
  // Queue: decouple front from back so either side can stall alone
  // ---------------------------------------------------------------------------
  bts_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // ---------------------------------------------------------------------------
  // Back: advance mode, phase and minutes; hold the result in the output register
  // ---------------------------------------------------------------------------
  bts_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .item_valid           (q_valid),
    .item_ready           (q_ready),
    .item                 (q_item),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_setting_mode     (out_setting_mode),
    .out_selected_phase   (out_selected_phase),
    .out_selected_minutes (out_selected_minutes),
    .out_value_changed    (out_value_changed)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A step is only applied while in setting mode
  a_chg_in_setting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_value_changed |-> out_setting_mode)
    else $error("value change reported outside setting mode");

  // The phase never reaches the unused code
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_selected_phase != 2'd3)
    else $error("selected phase out of range");

  // A stepped value is saturated to the upper bound
  a_step_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_value_changed |-> out_selected_minutes <= cfg_r.max_minutes)
    else $error("stepped minutes above upper bound");

endmodule

>>> tb/button_time_setter_tb.sv
module button_time_setter_tb;
  import bts_pkg::*;

  // Active-low button levels, spelled out so the scan sequences read naturally
  localparam logic PRESSED  = 1'b0;
  localparam logic RELEASED = 1'b1;

  // Cycles without any accepted transaction before the run is declared hung
  localparam int STALL_LIMIT = 2000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic             setting_mode;
    logic [1:0]       phase;
    logic [MIN_W-1:0] minutes;
    logic             changed;
  } scan_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [TS_W-1:0]    in_now_ms = '0;
  logic               in_mode_level = RELEASED;
  logic               in_up_level = RELEASED;
  logic               in_down_level = RELEASED;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_setting_mode;
  logic [1:0]         out_selected_phase;
  logic [MIN_W-1:0]   out_selected_minutes;
  logic               out_value_changed;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  button_time_setter i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_now_ms            (in_now_ms),
    .in_mode_level        (in_mode_level),
    .in_up_level          (in_up_level),
    .in_down_level        (in_down_level),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_setting_mode     (out_setting_mode),
    .out_selected_phase   (out_selected_phase),
    .out_selected_minutes (out_selected_minutes),
    .out_value_changed    (out_value_changed),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shadow of the setter: register values and everything the scans update
  bts_cfg_t         cfg;
  logic             setting_on;
  logic [1:0]       cur_phase;
  logic [MIN_W-1:0] minutes [PHASE_COUNT];
  logic [5:0]       btn_hist;      // mode now/before, up now/before, down now/before
  logic             entry_pending; // the press that entered setting mode is still held
  logic [TS_W-1:0]  mode_down_ms;
  logic             rep_on;
  logic             rep_dir_up;
  logic [TS_W-1:0]  step_down_ms;
  logic [TS_W-1:0]  rep_due_ms;

  scan_result_t expected_results [$];
  idle_mode_t   idle_mode = IDLE_NONE;
  int           hold_off_left = 0;
  int           quiet_cycles = 0;
  int           error_count = 0;
  int           scans_sent = 0;
  int           results_checked = 0;
  int           steps_checked = 0;
  int           settings_applied = 0;
  logic [TS_W-1:0] now_ms_tb = '0;

  task automatic reset_shadow();
    cfg.long_press_ms      = LONG_PRESS_RST;
    cfg.repeat_interval_ms = REPEAT_RST;
    cfg.fast_hold_ms       = FAST_HOLD_RST;
    cfg.fast_step          = FAST_STEP_RST;
    cfg.max_minutes        = MAX_MIN_RST;
    setting_on    = 1'b0;
    cur_phase     = PHASE_KNEAD;
    minutes       = PHASE_MIN_RST;
    btn_hist      = 6'h3F;
    entry_pending = 1'b0;
    mode_down_ms  = '0;
    rep_on        = 1'b0;
    rep_dir_up    = 1'b0;
    step_down_ms  = '0;
    rep_due_ms    = '0;
  endtask

  // Step the selected phase and clamp it to 0..max_minutes
  function automatic void bump_minutes(input int unsigned amount, input logic go_up);
    int v;
    if (cur_phase >= PHASE_COUNT) return;
    v = int'(minutes[cur_phase]);
    v = go_up ? v + int'(amount) : v - int'(amount);
    if (v < 0) v = 0;
    if (v > int'(cfg.max_minutes)) v = int'(cfg.max_minutes);
    minutes[cur_phase] = v[MIN_W-1:0];
  endfunction

  // Advance the shadow by one scan and return what the block should report
  function automatic scan_result_t predict_scan(input logic [TS_W-1:0] now,
                                                input logic m_lv, u_lv, d_lv);
    logic            m_prev, u_prev, d_prev, lvl_change, held, stepped;
    logic [TS_W-1:0] since;
    scan_result_t    r;
    stepped = 1'b0;

    // Mode button: press enters or timestamps, release cycles or exits
    m_prev = btn_hist[0];
    btn_hist[1:0] = {m_prev, m_lv};
    if (m_prev != m_lv && m_lv == PRESSED) begin
      if (!setting_on) begin
        setting_on    = 1'b1;
        cur_phase     = PHASE_KNEAD;
        entry_pending = 1'b1;
      end else begin
        mode_down_ms = now;
      end
    end else if (m_prev != m_lv) begin
      if (setting_on && !entry_pending) begin
        since = now - mode_down_ms;
        if (since >= TS_W'(cfg.long_press_ms)) begin
          setting_on = 1'b0;
        end else begin
          case (cur_phase)
            PHASE_KNEAD: cur_phase = PHASE_RAISE;
            PHASE_RAISE: cur_phase = PHASE_BAKE;
            default:     cur_phase = PHASE_KNEAD;
          endcase
        end
      end
      entry_pending = 1'b0;
    end

    // Up and down only count while setting mode holds after the mode update
    if (setting_on) begin
      u_prev = btn_hist[2];
      d_prev = btn_hist[4];
      btn_hist[5:2] = {d_prev, d_lv, u_prev, u_lv};
      lvl_change = (u_prev != u_lv) || (d_prev != d_lv);
      held = (d_lv == PRESSED) || (u_lv == PRESSED);
      if (d_lv == PRESSED) rep_dir_up = 1'b0;
      else if (u_lv == PRESSED) rep_dir_up = 1'b1;

      if (lvl_change && held) begin
        step_down_ms = now;
        rep_on       = 1'b1;
        rep_due_ms   = now + (TS_W'(cfg.repeat_interval_ms) << 1);
        bump_minutes(1, rep_dir_up);
        stepped = 1'b1;
      end else if (lvl_change) begin
        rep_on = 1'b0;
      end else if (rep_on) begin
        // Signed distance to the due time: a scan in the past never repeats
        since = now - rep_due_ms;
        if (!since[TS_W-1] && since >= TS_W'(cfg.repeat_interval_ms)) begin
          rep_due_ms = now;
          since = now - step_down_ms;
          bump_minutes((since >= TS_W'(cfg.fast_hold_ms)) ? cfg.fast_step : 1, rep_dir_up);
          stepped = 1'b1;
        end
      end
    end

    r.setting_mode = setting_on;
    r.phase        = cur_phase;
    r.minutes      = (cur_phase < PHASE_COUNT) ? minutes[cur_phase] : '0;
    r.changed      = stepped;
    return r;
  endfunction

  // Offer one scan, hold it until the transaction completes, then maybe idle.
  // Leave in_valid high when no gap follows so the next scan can go back to back.
  task automatic send_scan(input logic [TS_W-1:0] ts, input logic m, u, d);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 83 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    in_valid      <= 1'b1;
    in_now_ms     <= ts;
    in_mode_level <= m;
    in_up_level   <= u;
    in_down_level <= d;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_scan(ts, m, u, d));
    scans_sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
  endtask

  task automatic scan_after(input int unsigned dt, input logic m, u, d);
    now_ms_tb += dt;
    send_scan(now_ms_tb, m, u, d);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register (setup + access), then read it back the same way
  task automatic write_register(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] mask, got;
    case (idx)
      REG_LONG_PRESS: begin
        mask = 32'h0000_FFFF;
        cfg.long_press_ms = value[MS_W-1:0];
      end
      REG_REPEAT: begin
        mask = 32'h0000_FFFF;
        cfg.repeat_interval_ms = value[MS_W-1:0];
      end
      REG_FAST_HOLD: begin
        mask = 32'h0000_FFFF;
        cfg.fast_hold_ms = value[MS_W-1:0];
      end
      REG_FAST_STEP: begin
        mask = 32'h0000_003F;
        cfg.fast_step = value[STEP_W-1:0];
      end
      default: begin
        mask = 32'h0000_1FFF;
        cfg.max_minutes = value[MIN_W-1:0];
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== (value & mask)) begin
      $error("register %0d readback: expected %0d, got %0d", idx, value & mask, got & mask);
      error_count++;
    end
  endtask

  task automatic set_config(input int unsigned lp, ri, fh, fs, mx);
    drain_results();
    write_register(REG_LONG_PRESS, lp);
    write_register(REG_REPEAT, ri);
    write_register(REG_FAST_HOLD, fh);
    write_register(REG_FAST_STEP, fs);
    write_register(REG_MAX_MIN, mx);
    settings_applied++;
  endtask

  task automatic enter_setting();
    scan_after($urandom_range(1, 30), RELEASED, RELEASED, RELEASED);
    scan_after($urandom_range(1, 30), PRESSED, RELEASED, RELEASED);
    scan_after($urandom_range(1, 30), RELEASED, RELEASED, RELEASED);
  endtask

  // Press up or down, keep it held over a number of scans, then let go
  task automatic hold_step_button(input logic go_up, input int scans,
                                  input int unsigned lo_dt, hi_dt);
    logic u, d;
    u = go_up ? PRESSED : RELEASED;
    d = go_up ? RELEASED : PRESSED;
    scan_after($urandom_range(1, 50), RELEASED, u, d);
    repeat (scans) scan_after($urandom_range(lo_dt, hi_dt), RELEASED, u, d);
    scan_after($urandom_range(1, 50), RELEASED, RELEASED, RELEASED);
  endtask

  task automatic random_gesture();
    int unsigned ri, lp;
    ri = cfg.repeat_interval_ms;
    lp = cfg.long_press_ms;
    idle_mode = idle_mode_t'($urandom_range(0, 3));
    // Most gestures only mean something in setting mode, so usually get there first
    if (!setting_on && $urandom_range(0, 3) != 0) enter_setting();
    case ($urandom_range(0, 9))
      0, 1: begin
        // short mode tap: cycle the phase
        scan_after($urandom_range(1, 40), PRESSED, RELEASED, RELEASED);
        scan_after((lp == 0) ? 0 : $urandom_range(0, lp - 1), RELEASED, RELEASED, RELEASED);
      end
      2: begin
        // long mode press: back to idle
        scan_after($urandom_range(1, 40), PRESSED, RELEASED, RELEASED);
        scan_after(lp + $urandom_range(0, 300), RELEASED, RELEASED, RELEASED);
      end
      3, 4, 5: hold_step_button(1'($urandom_range(0, 1)), $urandom_range(0, 40), 0, 2 * ri);
      6: begin
        // both buttons, then swap direction on a single scan
        scan_after($urandom_range(1, 50), RELEASED, PRESSED, RELEASED);
        scan_after($urandom_range(1, 50), RELEASED, PRESSED, PRESSED);
        repeat ($urandom_range(0, 6))
          scan_after($urandom_range(0, 2 * ri), RELEASED, PRESSED, PRESSED);
        scan_after($urandom_range(1, 50), RELEASED, RELEASED, PRESSED);
        scan_after($urandom_range(1, 50), RELEASED, PRESSED, RELEASED);
        scan_after($urandom_range(1, 50), RELEASED, RELEASED, RELEASED);
      end
      7: begin
        // noise: random levels at random, possibly backward, timestamps
        repeat ($urandom_range(1, 4)) begin
          now_ms_tb = $urandom();
          send_scan(now_ms_tb, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end
      end
      8: begin
        // hold across the timestamp wrap
        now_ms_tb = 32'hFFFF_FFFF - $urandom_range(0, 3 * ri);
        hold_step_button(1'($urandom_range(0, 1)), $urandom_range(2, 20), 0, 2 * ri);
      end
      default: begin
        repeat ($urandom_range(1, 3))
          scan_after($urandom_range(0, 3 * ri), RELEASED, RELEASED, RELEASED);
      end
    endcase
  endtask

  // Reset values: every special case of the mode and step logic once
  task automatic test_directed_cases();
    idle_mode = IDLE_NONE;
    now_ms_tb = '0;
    scan_after(0, RELEASED, RELEASED, RELEASED);
    scan_after(10, RELEASED, PRESSED, RELEASED);   // up in idle: not sampled
    scan_after(10, PRESSED, PRESSED, RELEASED);    // enter with up held: steps at once
    scan_after(10, RELEASED, PRESSED, RELEASED);   // release of the entering press
    scan_after(600, RELEASED, PRESSED, RELEASED);  // first repeat after the lead-in
    scan_after(100, RELEASED, PRESSED, RELEASED);  // too early for the next one
    scan_after(150, RELEASED, PRESSED, RELEASED);
    scan_after(10, RELEASED, PRESSED, PRESSED);    // both: down wins
    scan_after(10, RELEASED, PRESSED, RELEASED);   // down off, up still held: a press
    scan_after(10, RELEASED, RELEASED, RELEASED);  // let go: repeat stops
    scan_after(10, PRESSED, RELEASED, RELEASED);
    scan_after(100, RELEASED, RELEASED, RELEASED); // short: kneading to raising
    scan_after(10, RELEASED, RELEASED, PRESSED);
    scan_after(10, RELEASED, RELEASED, RELEASED);
    scan_after(10, PRESSED, RELEASED, RELEASED);
    scan_after(499, RELEASED, RELEASED, RELEASED); // one below the long press
    scan_after(10, PRESSED, RELEASED, PRESSED);
    scan_after(500, RELEASED, RELEASED, PRESSED);  // exactly long: exit, down unsampled
    scan_after(10, RELEASED, RELEASED, RELEASED);
    now_ms_tb = 32'hFFFF_FF80;
    scan_after(0, PRESSED, RELEASED, RELEASED);
    scan_after(16, RELEASED, RELEASED, RELEASED);
    scan_after(16, PRESSED, RELEASED, RELEASED);
    scan_after(256, RELEASED, RELEASED, RELEASED); // short press across the wrap
    scan_after(10, RELEASED, PRESSED, RELEASED);
    scan_after(32'h7FFF_FFFF, RELEASED, PRESSED, RELEASED); // due time far behind
    drain_results();
  endtask

  // Drive a value up to the top bound with large fast steps, then back down
  task automatic test_fast_saturation();
    idle_mode = IDLE_BOTH;
    enter_setting();
    hold_step_button(1'b1, 140, 1, 1);
    hold_step_button(1'b0, 20, 1, 1);
  endtask

  // Hold off the result side while scans keep coming, so the block backs up
  task automatic test_output_backpressure();
    idle_mode = IDLE_NONE;
    hold_off_left <= 150;
    enter_setting();
    hold_step_button(1'b1, 24, 0, 2 * cfg.repeat_interval_ms);
    drain_results();
  endtask

  task automatic test_random_phase(input int count);
    int target;
    target = scans_sent + count;
    while (scans_sent < target) random_gesture();
  endtask

  // Result side: stall as the idle mode says, or hold off for a counted stretch
  always @(posedge clk) begin
    int stall_pct;
    stall_pct = (idle_mode == IDLE_RECEIVER) ? 83 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    if (hold_off_left > 0) begin
      out_ready     <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare every result transaction against the oldest prediction
  always @(posedge clk) begin
    scan_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no scan waiting: mode %0d phase %0d minutes %0d",
               out_setting_mode, out_selected_phase, out_selected_minutes);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.changed) steps_checked++;
        if (out_setting_mode !== want.setting_mode) begin
          $error("setting_mode: expected %0d, got %0d", want.setting_mode, out_setting_mode);
          error_count++;
        end
        if (out_selected_phase !== want.phase) begin
          $error("selected_phase: expected %0d, got %0d", want.phase, out_selected_phase);
          error_count++;
        end
        if (out_selected_minutes !== want.minutes) begin
          $error("selected_minutes: expected %0d, got %0d", want.minutes,
                 out_selected_minutes);
          error_count++;
        end
        if (out_value_changed !== want.changed) begin
          $error("value_changed: expected %0d, got %0d", want.changed, out_value_changed);
          error_count++;
        end
      end
    end
  end

  // Watchdog: give up once nothing has moved on either channel for too long
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("button_time_setter_tb: done, errors");
    $finish;
  end

  initial begin
    reset_shadow();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();

    // Smallest times and largest step: every release exits, repeats every scan
    set_config(0, 1, 0, 63, 8191);
    test_fast_saturation();
    test_random_phase(80);

    // Largest times and a zero bound: every step clamps to zero
    set_config(65535, 65535, 65535, 1, 0);
    test_random_phase(90);

    set_config(500, 200, 2000, 5, 5999);
    test_output_backpressure();
    test_random_phase(90);

    set_config(300, 50, 400, 7, 200);
    test_random_phase(90);

    set_config($urandom_range(0, 2000), $urandom_range(1, 500), $urandom_range(0, 5000),
               $urandom_range(1, 63), $urandom_range(0, 8191));
    test_random_phase(90);

    idle_mode = IDLE_NONE;
    drain_results();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end

    $display("button_time_setter_tb: %0d scans, %0d results checked, %0d with a step",
             scans_sent, results_checked, steps_checked);
    $display("button_time_setter_tb: %0d register settings, long result hold-off, %s",
             settings_applied, "random idling on both sides");
    if (error_count == 0) begin
      $display("button_time_setter_tb: done, clean");
    end else begin
      $display("button_time_setter_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bts_pkg.sv
src/bts_front.sv
src/bts_queue.sv
src/bts_back.sv
src/button_time_setter.sv
tb/button_time_setter_tb.sv
